>>> hw/rtl/pfba_pkg.sv
// pfba_pkg: shared types, codes and constants of the page frame bitmap allocator
// used by pfba_word_unit and page_frame_bitmap_allocator_unit; no dependencies
package pfba_pkg;

	// bitmap word geometry: eight page bits per memory word
	localparam int WORD_BITS  = 8;
	localparam int WORD_IDX_W = 3;
	localparam int CHG_W      = 4;

	// field widths
	localparam int CMD_W   = 3;
	localparam int PAGE_W  = 20;
	localparam int COUNT_W = 17;
	localparam int GRANT_W = 16;
	localparam int CNT_W   = 17;

	localparam logic [CNT_W-1:0] CNT_MAX           = 17'h1FFFF;
	localparam logic [CNT_W-1:0] TOTAL_PAGES_RESET = 17'h10000;
	localparam int               DEFAULT_NUM_PAGES = 65536;

	// command codes
	localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOCK      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd4;

	// status codes
	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_NO_PAGE = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [PAGE_W-1:0]  first_page;
		logic [COUNT_W-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic               status;
		logic [GRANT_W-1:0] granted_page;
		logic [CNT_W-1:0]   free_pages;
		logic [CNT_W-1:0]   used_pages;
		logic [CNT_W-1:0]   reserved_pages;
	} rsp_t;

	// control into the word unit
	typedef struct packed {
		logic set;     // drive selected bits to one, else to zero
		logic single;  // change only the lowest candidate bit
	} word_op_t;

	// result of the word unit
	typedef struct packed {
		logic [WORD_BITS-1:0]  new_word;
		logic [CHG_W-1:0]      n_changed;
		logic                  any;
		logic [WORD_IDX_W-1:0] low_idx;
	} word_res_t;

endpackage

>>> hw/rtl/pfba_ram.sv
// pfba_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module pfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/pfba_word_unit.sv
// pfba_word_unit: modifies one bitmap word under a page mask, counts changed bits
// depends on pfba_pkg
module pfba_word_unit (
	input  logic [pfba_pkg::WORD_BITS-1:0] word,
	input  logic [pfba_pkg::WORD_BITS-1:0] mask,
	input  pfba_pkg::word_op_t             op,
	output pfba_pkg::word_res_t            res
);

	logic [pfba_pkg::WORD_BITS-1:0] cand;
	logic [pfba_pkg::WORD_BITS-1:0] changed;
	logic [pfba_pkg::WORD_IDX_W-1:0] low;
	logic [pfba_pkg::CHG_W-1:0] n;

	always_comb begin
		// bits in the mask that do not hold the wanted value yet
		cand = op.set ? (mask & ~word) : (mask & word);
		low = '0;
		for (int i = pfba_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				low = pfba_pkg::WORD_IDX_W'(i);
			end
		end
		if (op.single) begin
			changed = (|cand) ? (pfba_pkg::WORD_BITS'(1) << low) : '0;
		end else begin
			changed = cand;
		end
		n = '0;
		for (int i = 0; i < pfba_pkg::WORD_BITS; i++) begin
			n = n + pfba_pkg::CHG_W'(changed[i]);
		end
		res.new_word  = op.set ? (word | changed) : (word & ~changed);
		res.n_changed = n;
		res.any       = |cand;
		res.low_idx   = low;
	end

endmodule

>>> hw/rtl/page_frame_bitmap_allocator_unit.sv
// page_frame_bitmap_allocator_unit: top level of the bitmap page frame allocator
// depends on pfba_pkg, pfba_ram and pfba_word_unit
//
//   channel  dir  handshake                  payload
//   req      in   req_valid / req_ready      pfba_pkg::req_t (command, first_page, page_count)
//   rsp      out  rsp_valid / rsp_ready      pfba_pkg::rsp_t (status, granted_page, counts)
//   cfg      in   cfg_wen, no wait           cfg_wdata: total_pages
//
// one transaction at a time; each bitmap word scanned or touched is read (ST_RD) and then
// modified and written back (ST_MOD) in the single bitmap ram; ST_FIN then loads the result
// and returns to idle, so the next request is accepted only after that load
// after reset a clearing pass writes zero to every word (8192 words at 65536 pages)
// while req_ready stays low; cfg writes are taken throughout
// a finished result sits in the rsp register; only the next result load waits on rsp_ready
module page_frame_bitmap_allocator_unit #(
	parameter int NUM_PAGES = pfba_pkg::DEFAULT_NUM_PAGES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  pfba_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output pfba_pkg::rsp_t             rsp,
	input  logic                       cfg_wen,
	input  logic [pfba_pkg::CNT_W-1:0] cfg_wdata
);

	localparam int WB    = pfba_pkg::WORD_BITS;
	localparam int WI    = pfba_pkg::WORD_IDX_W;
	localparam int CW    = pfba_pkg::CNT_W;
	localparam int DEPTH = (NUM_PAGES + WB - 1) / WB;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW1   = $clog2(NUM_PAGES + 1);  // page numbers 0..NUM_PAGES
	localparam int SW    = PW1 + 1;                 // room for a word base plus one word
	localparam int EW    = 22;                      // first_page + page_count

	// controller states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [PW1-1:0] NP      = PW1'(NUM_PAGES);
	localparam logic [AW-1:0]  LAST_WA = AW'(DEPTH - 1);

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c,
		input logic [pfba_pkg::CHG_W-1:0] n);
		logic [CW:0] s;
		s = {1'b0, c} + (CW + 1)'(n);
		return (s > {1'b0, pfba_pkg::CNT_MAX}) ? pfba_pkg::CNT_MAX : s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] c,
		input logic [pfba_pkg::CHG_W-1:0] n);
		logic [CW-1:0] nn;
		nn = CW'(n);
		return (c > nn) ? (c - nn) : '0;
	endfunction

	logic [2:0]            state_q;
	logic [AW-1:0]         clr_addr_q;
	logic [pfba_pkg::CMD_W-1:0] cmd_q;
	logic [PW1-1:0]        cur_q;
	logic [PW1-1:0]        end_q;
	logic [PW1-1:0]        hint_q;
	logic [CW-1:0]         used_q;
	logic [CW-1:0]         rsvd_q;
	logic [CW-1:0]         total_q;
	logic                  status_q;
	logic [pfba_pkg::GRANT_W-1:0] granted_q;
	logic                  rsp_valid_q;
	pfba_pkg::rsp_t        rsp_q;

	// ram and word unit hookup
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WB-1:0]         ram_wdata;
	logic [AW-1:0]         word_addr;
	logic [WB-1:0]         ram_rdata;
	logic [WB-1:0]         mask;
	pfba_pkg::word_op_t    wop;
	pfba_pkg::word_res_t   wres;

	logic [SW-1:0]         base;
	logic [SW-1:0]         next_base;
	logic [SW-1:0]         low_page;
	logic                  last_word;
	logic                  slot_free;

	// request decode at accept
	logic                  is_req;
	logic                  is_run;
	logic [EW-1:0]         run_end_w;
	logic [PW1-1:0]        start_c;
	logic [PW1-1:0]        end_c;

	// free count
	logic [CW:0]           spent;
	logic [CW-1:0]         free_c;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	assign word_addr = AW'(cur_q >> WI);
	assign ram_we    = (state_q == ST_CLR) || (state_q == ST_MOD);
	assign ram_waddr = (state_q == ST_CLR) ? clr_addr_q : word_addr;
	assign ram_wdata = (state_q == ST_CLR) ? '0 : wres.new_word;

	pfba_ram #(
		.WIDTH (WB),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (word_addr),
		.rdata (ram_rdata)
	);

	// set for request, lock and reserve; request changes only the first free bit
	assign wop.set    = (cmd_q == pfba_pkg::CMD_REQUEST) || (cmd_q == pfba_pkg::CMD_LOCK)
		|| (cmd_q == pfba_pkg::CMD_RESERVE);
	assign wop.single = (cmd_q == pfba_pkg::CMD_REQUEST);

	pfba_word_unit u_word (
		.word (ram_rdata),
		.mask (mask),
		.op   (wop),
		.res  (wres)
	);

	// page window of the current word: pages in [cur_q, end_q)
	always_comb begin
		logic [SW-1:0] pg;
		base = SW'({cur_q[PW1-1:WI], {WI{1'b0}}});
		mask = '0;
		for (int b = 0; b < WB; b++) begin
			pg = base + SW'(b);
			mask[b] = (pg >= SW'(cur_q)) && (pg < SW'(end_q));
		end
		next_base = base + SW'(WB);
		last_word = (next_base >= SW'(end_q));
		low_page  = base + SW'(wres.low_idx);
	end

	// start and end of a run, both clipped to the bitmap
	always_comb begin
		is_req    = (req.command == pfba_pkg::CMD_REQUEST);
		is_run    = (req.command == pfba_pkg::CMD_FREE) || (req.command == pfba_pkg::CMD_LOCK)
			|| (req.command == pfba_pkg::CMD_RESERVE)
			|| (req.command == pfba_pkg::CMD_UNRESERVE);
		run_end_w = EW'(req.first_page) + EW'(req.page_count);
		start_c   = (EW'(req.first_page) >= EW'(NUM_PAGES)) ? NP : PW1'(req.first_page);
		end_c     = (run_end_w >= EW'(NUM_PAGES)) ? NP : PW1'(run_end_w);
	end

	// free pages, saturating at zero
	always_comb begin
		spent  = (CW + 1)'(used_q) + (CW + 1)'(rsvd_q);
		free_c = ({1'b0, total_q} > spent) ? CW'({1'b0, total_q} - spent) : '0;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= pfba_pkg::TOTAL_PAGES_RESET;
		end else if (cfg_wen) begin
			total_q <= cfg_wdata;
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			cmd_q       <= pfba_pkg::CMD_REQUEST;
			cur_q       <= '0;
			end_q       <= '0;
			hint_q      <= '0;
			used_q      <= '0;
			rsvd_q      <= '0;
			status_q    <= pfba_pkg::STATUS_DONE;
			granted_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// in ST_FIN the load below decides rsp_valid_q
			if (rsp_valid_q && rsp_ready && (state_q != ST_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					// zero the bitmap one word a cycle
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_WA) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q     <= req.command;
						status_q  <= pfba_pkg::STATUS_DONE;
						granted_q <= '0;
						if (is_req) begin
							// scan from the hint to the end of the bitmap
							cur_q <= hint_q;
							end_q <= NP;
							if (hint_q >= NP) begin
								status_q <= pfba_pkg::STATUS_NO_PAGE;
								state_q  <= ST_FIN;
							end else begin
								state_q <= ST_RD;
							end
						end else if (is_run) begin
							cur_q <= start_c;
							end_q <= end_c;
							state_q <= (start_c >= end_c) ? ST_FIN : ST_RD;
						end else begin
							// unknown command: result only
							state_q <= ST_FIN;
						end
					end
				end
				ST_RD: begin
					// read of word_addr is in flight
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					// word written back this cycle; update counts and hint
					case (cmd_q)
						pfba_pkg::CMD_REQUEST,
						pfba_pkg::CMD_LOCK: begin
							used_q <= sat_add(used_q, wres.n_changed);
						end
						pfba_pkg::CMD_FREE: begin
							used_q <= sat_sub(used_q, wres.n_changed);
						end
						pfba_pkg::CMD_RESERVE: begin
							rsvd_q <= sat_add(rsvd_q, wres.n_changed);
						end
						pfba_pkg::CMD_UNRESERVE: begin
							rsvd_q <= sat_sub(rsvd_q, wres.n_changed);
						end
						default: begin
						end
					endcase
					if (cmd_q == pfba_pkg::CMD_REQUEST) begin
						if (wres.any) begin
							// grant: hint stays on the granted page
							hint_q    <= PW1'(low_page);
							granted_q <= pfba_pkg::GRANT_W'(low_page);
							state_q   <= ST_FIN;
						end else if (last_word) begin
							hint_q   <= NP;
							status_q <= pfba_pkg::STATUS_NO_PAGE;
							state_q  <= ST_FIN;
						end else begin
							cur_q   <= PW1'(next_base);
							state_q <= ST_RD;
						end
					end else begin
						// clearing commands pull the hint down to the lowest cleared page
						if (!wop.set && wres.any && (SW'(hint_q) > low_page)) begin
							hint_q <= PW1'(low_page);
						end
						if (last_word) begin
							state_q <= ST_FIN;
						end else begin
							cur_q   <= PW1'(next_base);
							state_q <= ST_RD;
						end
					end
				end
				ST_FIN: begin
					// load the result once the output register is free
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			rsp_q.status         <= status_q;
			rsp_q.granted_page   <= granted_q;
			rsp_q.free_pages     <= free_c;
			rsp_q.used_pages     <= used_q;
			rsp_q.reserved_pages <= rsvd_q;
		end
	end

endmodule

>>> dv/pfba_checker.sv
// pfba_checker: passive monitor of the allocator request, response and config channels
// keeps its own copy of the page bitmap and counters; depends on pfba_pkg
module pfba_checker #(
	parameter int NUM_PAGES = pfba_pkg::DEFAULT_NUM_PAGES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  pfba_pkg::req_t             req,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  pfba_pkg::rsp_t             rsp,
	input  logic                       cfg_wen,
	input  logic [pfba_pkg::CNT_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         pending_cnt
);
	import pfba_pkg::*;

	localparam int REPORT_LIMIT = 10;

	bit          page_busy [NUM_PAGES];
	int unsigned scan_hint;
	int unsigned used_cnt;
	int unsigned resv_cnt;
	int unsigned total_pages;
	rsp_t        expected_rsp_q [$];

	function automatic int unsigned sat_inc(input int unsigned c);
		return (c < CNT_MAX) ? c + 1 : CNT_MAX;
	endfunction

	function automatic int unsigned sat_dec(input int unsigned c);
		return (c > 0) ? c - 1 : 0;
	endfunction

	// applies one command to the bitmap and counters, returns the response it gives
	function automatic rsp_t apply_command(input req_t item);
		int unsigned pg;
		int unsigned idx;
		int unsigned spent;
		bit          setting;
		rsp_t        res;
		res = '0;
		case (item.command)
			CMD_REQUEST: begin
				pg = scan_hint;
				while (pg < NUM_PAGES && page_busy[pg])
					pg++;
				scan_hint = pg;
				if (pg < NUM_PAGES) begin
					page_busy[pg] = 1'b1;
					used_cnt = sat_inc(used_cnt);
					res.granted_page = pg[GRANT_W-1:0];
				end else begin
					res.status = STATUS_NO_PAGE;
				end
			end
			CMD_FREE, CMD_LOCK, CMD_RESERVE, CMD_UNRESERVE: begin
				setting = (item.command == CMD_LOCK) || (item.command == CMD_RESERVE);
				for (idx = 0; idx < item.page_count; idx++) begin
					pg = item.first_page + idx;
					if (pg >= NUM_PAGES || page_busy[pg] == setting)
						continue;
					page_busy[pg] = setting;
					case (item.command)
						CMD_FREE:    used_cnt = sat_dec(used_cnt);
						CMD_LOCK:    used_cnt = sat_inc(used_cnt);
						CMD_RESERVE: resv_cnt = sat_inc(resv_cnt);
						default:     resv_cnt = sat_dec(resv_cnt);
					endcase
					if (!setting && scan_hint > pg)
						scan_hint = pg;
				end
			end
			default: ;
		endcase
		spent = used_cnt + resv_cnt;
		res.free_pages     = (total_pages > spent) ? CNT_W'(total_pages - spent) : '0;
		res.used_pages     = CNT_W'(used_cnt);
		res.reserved_pages = CNT_W'(resv_cnt);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			foreach (page_busy[i])
				page_busy[i] = 1'b0;
			scan_hint   = 0;
			used_cnt    = 0;
			resv_cnt    = 0;
			total_pages = TOTAL_PAGES_RESET;
			expected_rsp_q.delete();
			fail_count  = 0;
			pending_cnt = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("[%0t] response with nothing outstanding: %p", $realtime, rsp);
					fail_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status || rsp.granted_page !== want.granted_page ||
					    rsp.free_pages !== want.free_pages ||
					    rsp.used_pages !== want.used_pages ||
					    rsp.reserved_pages !== want.reserved_pages) begin
						if (fail_count < REPORT_LIMIT)
							$display("[%0t] response mismatch: expected %p, got %p",
								$realtime, want, rsp);
						fail_count++;
					end
				end
			end
			if (cfg_wen)
				total_pages = cfg_wdata;
			if (req_valid && req_ready)
				expected_rsp_q.push_back(apply_command(req));
			pending_cnt = expected_rsp_q.size();
		end
	end

endmodule

>>> dv/tb_top.sv
// tb_top: stimulus and verdict for page_frame_bitmap_allocator_unit
// depends on pfba_pkg, the allocator rtl and pfba_checker
module tb_top;
	import pfba_pkg::*;

	localparam int NUM_PAGES    = DEFAULT_NUM_PAGES;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 10;
	// worst quiet stretch: clearing pass plus one full-bitmap transaction
	// plus receiver stall, taken several times over
	localparam int WATCHDOG_LIMIT  = 150000;
	localparam int RANDOM_PHASES   = 4;
	localparam int ITEMS_PER_PHASE = 212;
	localparam int SETTLE_CYCLES   = 40;
	localparam int CFG_HOLDOFF     = 4;

	localparam logic [CMD_W-1:0] CMD_TOP_CODE = '1;
	localparam int unsigned      PAGE_MAX     = (1 << PAGE_W) - 1;
	localparam int unsigned      RUN_MAX      = NUM_PAGES;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_wen   = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;

	int fail_count;
	int pending_cnt;
	int idle_cycles = 0;

	// sender pacing state
	int burst_left = 0;
	bit gaps_on    = 1'b1;

	// receiver stall pattern: ready while stall_phase, counting round stall_period, is below stall_duty
	logic        ready_free   = 1'b1;
	int unsigned stall_period = 4;
	int unsigned stall_duty   = 2;
	int unsigned stall_phase  = 0;

	always #HALF_PERIOD clk = ~clk;

	page_frame_bitmap_allocator_unit #(
		.NUM_PAGES(NUM_PAGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	pfba_checker #(
		.NUM_PAGES(NUM_PAGES)
	) checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending_cnt(pending_cnt)
	);

	// response side back-pressure, runs on its own period so stalls drift across
	// every phase of the word scan
	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
		rsp_ready   <= ready_free || (stall_phase < stall_duty);
	end

	// watchdog: any transaction on either channel restarts the count
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic req_t make_item(input logic [CMD_W-1:0] cmd, input int unsigned first,
		input int unsigned count);
		req_t item;
		item.command    = cmd;
		item.first_page = first[PAGE_W-1:0];
		item.page_count = count[COUNT_W-1:0];
		return item;
	endfunction

	// random command; runs stay mostly short and low so request scans stay cheap,
	// with a few pages near or past the end and a rare long run
	function automatic req_t random_item();
		int unsigned      pick;
		int unsigned      first;
		int unsigned      count;
		logic [CMD_W-1:0] cmd;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			cmd = CMD_REQUEST;
		else if (pick < 55)
			cmd = CMD_FREE;
		else if (pick < 70)
			cmd = CMD_LOCK;
		else if (pick < 82)
			cmd = CMD_RESERVE;
		else if (pick < 96)
			cmd = CMD_UNRESERVE;
		else
			cmd = CMD_W'($urandom_range(CMD_UNRESERVE + 1, CMD_TOP_CODE));
		pick = $urandom_range(0, 99);
		if (pick < 85)
			first = $urandom_range(0, 1023);
		else if (pick < 93)
			first = NUM_PAGES - 64 + $urandom_range(0, 127);
		else
			first = $urandom_range(0, PAGE_MAX);
		pick = $urandom_range(0, 199);
		if (pick < 140)
			count = $urandom_range(0, 16);
		else if (pick < 190)
			count = $urandom_range(0, 300);
		else if (pick < 198)
			count = $urandom_range(0, 4095);
		else if (pick < 199)
			count = RUN_MAX;
		else
			count = $urandom_range(0, RUN_MAX);
		return make_item(cmd, first, count);
	endfunction

	// drop valid and wait until the checker has nothing outstanding
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_cnt != 0);
		@(posedge clk);
	endtask

	// burst / gap pacing of the sender, with an occasional full drain
	task automatic pace();
		int gap;
		if ($urandom_range(0, 63) == 0)
			wait_drained();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 12);
			gap = gaps_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// present one transaction and hold it until accepted; valid stays up on return
	task automatic issue(input req_t item);
		pace();
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	// total_pages only changes while the allocator has nothing in flight
	task automatic write_total(input int unsigned value);
		wait_drained();
		repeat (CFG_HOLDOFF) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value[CNT_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_receiver(input bit never_stall);
		int unsigned per;
		per = $urandom_range(2, 16);
		ready_free   <= never_stall || ($urandom_range(0, 3) == 0);
		stall_period <= per;
		stall_duty   <= $urandom_range(1, per - 1);
	endtask

	initial begin : stimulus
		int ph;
		int n;
		int code;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, default page total written back explicitly
		write_total(NUM_PAGES);
		set_receiver(1'b0);
		issue(make_item(CMD_REQUEST, 0, 0));
		issue(make_item(CMD_REQUEST, 1, RUN_MAX));
		issue(make_item(CMD_LOCK, 4, 4));
		// next grants skip the locked pages
		issue(make_item(CMD_REQUEST, 0, 0));
		issue(make_item(CMD_REQUEST, 0, 0));
		issue(make_item(CMD_REQUEST, 0, 0));
		// free pulls the hint back down
		issue(make_item(CMD_FREE, 0, 2));
		issue(make_item(CMD_REQUEST, PAGE_MAX, 0));
		issue(make_item(CMD_RESERVE, 100, 8));
		// pages already reserved are skipped
		issue(make_item(CMD_RESERVE, 100, 8));
		// free of a reserved page counts against used
		issue(make_item(CMD_FREE, 100, 1));
		issue(make_item(CMD_UNRESERVE, 100, 8));
		// unreserve of locked pages drives the reserved count into its floor
		issue(make_item(CMD_LOCK, 200, 4));
		issue(make_item(CMD_UNRESERVE, 200, 4));
		// undefined command codes change nothing
		for (code = CMD_UNRESERVE + 1; code <= CMD_TOP_CODE; code++)
			issue(make_item(code[CMD_W-1:0], $urandom_range(0, PAGE_MAX),
				$urandom_range(0, RUN_MAX)));
		issue(make_item(CMD_FREE, 300, 0));
		// run entirely past the bitmap, then one straddling its end
		issue(make_item(CMD_LOCK, PAGE_MAX, RUN_MAX));
		issue(make_item(CMD_LOCK, NUM_PAGES - 6, 20));
		// fill the whole bitmap; requests then find nothing and the hint parks at the end
		issue(make_item(CMD_LOCK, 0, RUN_MAX));
		issue(make_item(CMD_REQUEST, 0, 0));
		issue(make_item(CMD_REQUEST, 0, 0));
		issue(make_item(CMD_FREE, 0, RUN_MAX));

		// random phases, each with its own page total and back-pressure shape;
		// phase 1 runs with neither gaps nor stalls
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       write_total(0);
				1:       write_total($urandom_range(1, NUM_PAGES - 1));
				2:       write_total(NUM_PAGES);
				default: write_total($urandom_range(0, NUM_PAGES));
			endcase
			gaps_on = (ph != 1);
			set_receiver(ph == 1);
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				issue(random_item());
		end

		// counter ceilings: used first, then reserved
		write_total(NUM_PAGES);
		gaps_on = 1'b1;
		set_receiver(1'b0);
		issue(make_item(CMD_UNRESERVE, 0, RUN_MAX));
		issue(make_item(CMD_LOCK, 0, RUN_MAX));
		issue(make_item(CMD_UNRESERVE, 0, RUN_MAX));
		issue(make_item(CMD_LOCK, 0, RUN_MAX));
		issue(make_item(CMD_UNRESERVE, 0, RUN_MAX));
		issue(make_item(CMD_RESERVE, 0, RUN_MAX));
		issue(make_item(CMD_FREE, 0, RUN_MAX));
		issue(make_item(CMD_RESERVE, 0, RUN_MAX));

		// drain, then give the block time to show any stray response
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/pfba_pkg.sv
hw/rtl/pfba_ram.sv
hw/rtl/pfba_word_unit.sv
hw/rtl/page_frame_bitmap_allocator_unit.sv
dv/pfba_checker.sv
dv/tb_top.sv
